// ----- sv/nsi_pkg.sv -----
// ============================================================================
// nsi_pkg
// Shared types, constants and helpers for the name scanner / interning unit.
// ============================================================================
package nsi_pkg;

    localparam int CHAR_W = 8;  // one text byte
    localparam int LEN_W  = 4;  // stored name length, holds 0..8

    // Controller sequence for one finished name.
    typedef enum logic [1:0] {
        ST_IDLE,     // taking text bytes
        ST_MATCH,    // every cell compares the pending name
        ST_RESOLVE,  // one-hot match folded into an index
        ST_COMMIT    // result loaded, new name appended if needed
    } state_t;

    // Strobes broadcast from the controller to every table cell.
    typedef struct packed {
        logic lookup;  // register the compare result
        logic append;  // first free cell captures the pending name
    } cell_ctrl_t;

    // ASCII digit or letter
    function automatic logic is_name_char(input logic [CHAR_W-1:0] c);
        logic res;
        res = ((c >= 8'h30) && (c <= 8'h39)) ||
              ((c >= 8'h41) && (c <= 8'h5A)) ||
              ((c >= 8'h61) && (c <= 8'h7A));
        return res;
    endfunction

endpackage

// ----- sv/name_scanner_with_interning_unit.sv -----
// ============================================================================
// name_scanner_with_interning_unit
// Gathers letters and digits into names and interns them in a symbol table.
//
// Input stream: one text byte per transaction on s_axis (tdata[7:0]);
// tlast marks end of text, the byte is then ignored. Letters and digits
// extend the pending name (first MAX_NAME_CHARS kept, the rest only set
// the truncation flag). Any other byte, or tlast, finishes a pending name.
// Output stream: one transaction per finished name on m_axis carrying the
// table index, stored length and the new / truncated / full flags.
// A byte that finishes no name is taken at once while idle. A byte that
// finishes a name runs through compare in every table cell, fold of the
// one-hot match into an index, then commit; no further byte is taken
// until the commit step has loaded its result into the m_axis register.
// The table is a chain of TABLE_ENTRIES cells; each cell learns from its
// left neighbor whether it is the first free one when a name is appended.
// Reset empties the table and the pending name; no sweep is needed.
// While a result waits on m_axis, bytes that finish no name are still
// taken; a finishing byte waits in the commit step until m_axis drains.
// ============================================================================
module name_scanner_with_interning_unit
    import nsi_pkg::*;
#(
    parameter  int MAX_NAME_CHARS = 8,
    parameter  int TABLE_ENTRIES  = 64,
    localparam int NAME_W         = CHAR_W * MAX_NAME_CHARS,
    localparam int IDX_W          = $clog2(TABLE_ENTRIES),
    localparam int OUT_DATA_W     = ((IDX_W + LEN_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // [7:0] char_in
    input  logic [7:0]            s_axis_tdata,
    input  logic                  s_axis_tlast,   // end_of_text
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [IDX_W-1:0] name_index, [IDX_W+3:IDX_W] name_length, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] is_new, [1] truncated, [2] table_full
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    state_t              state_reg, state_next;

    // pending name
    logic [NAME_W-1:0]   chars_reg, chars_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;

    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;

    logic                m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [2:0]          m_user_reg, m_user_next;

    logic                in_fire;
    logic                name_char;
    logic                finish;
    logic                out_free;
    logic                commit_fire;
    logic                resolve_en;
    logic                table_full;
    cell_ctrl_t          ctrl;

    logic [TABLE_ENTRIES-1:0] occupied;
    logic [TABLE_ENTRIES-1:0] match;
    logic                hit;
    logic [IDX_W-1:0]    hit_index;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign name_char  = !s_axis_tlast && is_name_char(s_axis_tdata);
    assign finish     = !name_char && (count_reg != '0);
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign table_full = (entry_count_reg == CNT_W'(TABLE_ENTRIES));

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && finish)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:   state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ctrl.lookup   = 1'b0;
        resolve_en    = 1'b0;
        commit_fire   = 1'b0;
        case (state_reg)
            ST_IDLE:    s_axis_tready = 1'b1;
            ST_MATCH:   ctrl.lookup   = 1'b1;
            ST_RESOLVE: resolve_en    = 1'b1;
            ST_COMMIT:  commit_fire   = out_free;
            default:    s_axis_tready = 1'b0;
        endcase
        ctrl.append = commit_fire && !hit && !table_full;
    end

    // ------------------------------------------------------- pending name
    // Pending name stays put through the lookup and is cleared at commit.
    always_comb
    begin
        chars_next = chars_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (commit_fire)
        begin
            chars_next = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (in_fire)
        begin
            if (name_char)
            begin
                if (count_reg < LEN_W'(MAX_NAME_CHARS))
                begin
                    for (int j = 0; j < MAX_NAME_CHARS; j++)
                    begin
                        if (count_reg == LEN_W'(j))
                        begin
                            chars_next[CHAR_W*j +: CHAR_W] = s_axis_tdata;
                        end
                    end
                    count_next = count_reg + LEN_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (count_reg == '0)
            begin
                // separator with nothing gathered: no result
                chars_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    assign entry_count_next = ctrl.append ? entry_count_reg + CNT_W'(1)
                                          : entry_count_reg;

    // ------------------------------------------------------- result regs
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (commit_fire)
        begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            if (hit)
            begin
                m_data_next[IDX_W-1:0] = hit_index;
            end
            else if (!table_full)
            begin
                m_data_next[IDX_W-1:0] = entry_count_reg[IDX_W-1:0];
            end
            m_data_next[IDX_W +: LEN_W] = count_reg;
            m_user_next = {!hit && table_full, ovf_reg, !hit && !table_full};
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            chars_reg       <= '0;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            entry_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            chars_reg       <= chars_next;
            count_reg       <= count_next;
            ovf_reg         <= ovf_next;
            entry_count_reg <= entry_count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // ------------------------------------------------------- cell chain
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        logic left_occupied;
        if (g == 0)
        begin : g_head
            assign left_occupied = 1'b1;
        end
        else
        begin : g_link
            assign left_occupied = occupied[g-1];
        end

        nsi_cell #(
            .NAME_W (NAME_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .key_name      (chars_reg),
            .key_len       (count_reg),
            .prev_occupied (left_occupied),
            .occupied      (occupied[g]),
            .match         (match[g])
        );
    end

    nsi_match_encode #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_encode (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (resolve_en),
        .match (match),
        .hit   (hit),
        .index (hit_index)
    );

endmodule

// ----- sv/nsi_cell.sv -----
// ============================================================================
// nsi_cell
// One table entry: stored name, length, occupied flag and compare result.
// ============================================================================
module nsi_cell
    import nsi_pkg::*;
#(
    parameter int NAME_W = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [NAME_W-1:0] key_name,
    input  logic [LEN_W-1:0]  key_len,
    input  logic              prev_occupied,  // from the left neighbor
    output logic              occupied,       // to the right neighbor
    output logic              match
);

    logic              occupied_reg;
    logic              match_reg;
    logic [NAME_W-1:0] name_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              take;

    // occupancy is a thermometer along the chain: first empty cell takes it
    assign take = ctrl.append && prev_occupied && !occupied_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
            match_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                occupied_reg <= 1'b1;
            end
            if (ctrl.lookup)
            begin
                match_reg <= occupied_reg && (name_reg == key_name) &&
                             (len_reg == key_len);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            name_reg <= key_name;
            len_reg  <= key_len;
        end
    end

    assign occupied = occupied_reg;
    assign match    = match_reg;

endmodule

// ----- sv/nsi_match_encode.sv -----
// ============================================================================
// nsi_match_encode
// Folds the cells' match flags into a registered hit flag and index.
// ============================================================================
module nsi_match_encode
    import nsi_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int IDX_W   = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [ENTRIES-1:0] match,
    output logic               hit,
    output logic [IDX_W-1:0]   index
);

    logic             hit_reg;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_or;

    // names are unique in the table, so at most one flag is set: plain OR
    always_comb
    begin
        index_or = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
            begin
                index_or = index_or | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (en)
        begin
            hit_reg <= |match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            index_reg <= index_or;
        end
    end

    assign hit   = hit_reg;
    assign index = index_reg;

endmodule

// ----- sv/nsi_checker.sv -----
// ============================================================================
// nsi_checker
// Port-level checks for the name scanner / interning unit, bound to the top.
// ============================================================================
module nsi_checker
    import nsi_pkg::*;
#(
    parameter  int MAX_NAME_CHARS = 8,
    parameter  int TABLE_ENTRIES  = 64,
    localparam int IDX_W          = $clog2(TABLE_ENTRIES),
    localparam int OUT_DATA_W     = ((IDX_W + LEN_W + 7) / 8) * 8
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic [7:0]            s_axis_tdata,
    input logic                  s_axis_tlast,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [2:0]            m_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready
);

    logic [LEN_W-1:0] out_len;
    logic             char_fire;

    assign out_len   = m_axis_tdata[IDX_W +: LEN_W];
    assign char_fire = s_axis_tvalid && s_axis_tready && !s_axis_tlast &&
                       is_name_char(s_axis_tdata);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // reported names are never empty and never longer than the kept limit
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (out_len != '0) && (out_len <= LEN_W'(MAX_NAME_CHARS)))
        else $error("name length out of range");

    // a rejected name is neither new nor given an index
    a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            !m_axis_tuser[0] && (m_axis_tdata[IDX_W-1:0] == '0))
        else $error("table full with new entry or index");

    // a letter or digit never causes a result
    a_char_silent: assert property (@(posedge clk) disable iff (!rst_n)
        char_fire |=> !$rose(m_axis_tvalid))
        else $error("result after a name character");

endmodule

bind name_scanner_with_interning_unit nsi_checker #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .TABLE_ENTRIES  (TABLE_ENTRIES)
) u_nsi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
